// ----- design/stp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stp_pkg
// Shared types and constants of the stepper turn pulse sequencer.
// ----------------------------------------------------------------------------
package stp_pkg;

    localparam int unsigned PIN_W      = 12;
    localparam int unsigned PIN_IDX_W  = 4;
    localparam int unsigned MOTOR_W    = 3;
    localparam int unsigned PULSES_W   = 9;
    localparam int unsigned TIMER_W    = 16;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned CFG_IDX_W  = 2;

    localparam logic [MOTOR_W-1:0] NUM_MOTORS = 3'd6;

    localparam logic [PIN_W-1:0] DIR_MASK = 12'h555;

    localparam logic [15:0] HALF_PERIOD_RST   = 16'd50;
    localparam logic [7:0]  QUARTER_STEPS_RST = 8'd50;
    localparam logic [15:0] SETTLE_TIME_RST   = 16'd5000;

    localparam logic [CFG_IDX_W-1:0] REG_HALF_PERIOD   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_QUARTER_STEPS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SETTLE_TIME   = 2'd2;

    localparam logic ACT_MOVE = 1'b0;
    localparam logic ACT_TICK = 1'b1;

    typedef enum logic [3:0] {
        PH_IDLE   = 4'b0001,
        PH_HIGH   = 4'b0010,
        PH_LOW    = 4'b0100,
        PH_SETTLE = 4'b1000
    } phase_t;

    typedef struct packed {
        logic               action;
        logic [MOTOR_W-1:0] motor;
        logic               direction;
        logic               half_turn;
    } in_beat_t;

    typedef struct packed {
        logic [PIN_W-1:0] pins;
        logic             busy_res;
        logic             rejected;
        logic             move_done;
    } out_beat_t;

    typedef struct packed {
        logic [15:0] half_period;
        logic [7:0]  quarter_steps;
        logic [15:0] settle_time;
    } cfg_t;

endpackage

// ----- design/stp_cfg_regs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stp_cfg_regs
// Configuration registers: half period, pulses per quarter turn, settle time.
// ----------------------------------------------------------------------------
module stp_cfg_regs (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [stp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [stp_pkg::CFG_DATA_W-1:0]   cfg_data,
    output stp_pkg::cfg_t                    cfg
);
    import stp_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_HALF_PERIOD:   cfg_next.half_period   = cfg_data;
                REG_QUARTER_STEPS: cfg_next.quarter_steps = cfg_data[7:0];
                REG_SETTLE_TIME:   cfg_next.settle_time   = cfg_data;
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.half_period   <= HALF_PERIOD_RST;
            cfg_reg.quarter_steps <= QUARTER_STEPS_RST;
            cfg_reg.settle_time   <= SETTLE_TIME_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- design/stp_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stp_core
// Sequencer state and the single-pass update for one beat: command decode,
// pulse high/low timing, step count and settle gap.
// ----------------------------------------------------------------------------
module stp_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,
    input  stp_pkg::in_beat_t    item,
    input  stp_pkg::cfg_t        cfg,
    output stp_pkg::out_beat_t   res
);
    import stp_pkg::*;

    logic [PIN_W-1:0]    pin_word_reg, pin_word_next;
    phase_t              phase_reg, phase_next;
    logic [PULSES_W-1:0] pulses_left_reg, pulses_left_next;
    logic [TIMER_W-1:0]  tick_timer_reg, tick_timer_next;
    logic [MOTOR_W-1:0]  active_motor_reg, active_motor_next;

    logic [TIMER_W-1:0]  period_load;
    logic [PIN_IDX_W-1:0] pulse_idx;
    logic [PIN_IDX_W-1:0] new_idx;
    logic [PIN_W-1:0]    pulse_mask;
    logic [PIN_W-1:0]    new_mask;
    logic [PIN_W-1:0]    dir_word;
    logic [PULSES_W-1:0] new_pulses;
    logic [PULSES_W-1:0] pulses_dec;
    logic                expired;
    logic                rejected;
    logic                done;

    assign period_load = (cfg.half_period == '0) ? TIMER_W'(1) : cfg.half_period;
    assign pulse_idx   = {active_motor_reg, 1'b1};
    assign new_idx     = {item.motor, 1'b1};
    assign pulse_mask  = PIN_W'(1) << pulse_idx;
    assign new_mask    = PIN_W'(1) << new_idx;
    assign new_pulses  = item.half_turn ? {cfg.quarter_steps, 1'b0}
                                        : {1'b0, cfg.quarter_steps};
    assign pulses_dec  = (pulses_left_reg == '0) ? '0 : pulses_left_reg - PULSES_W'(1);
    assign expired     = tick_timer_reg <= TIMER_W'(1);
    assign dir_word    = item.direction ? (pin_word_reg & ~DIR_MASK)
                                        : (pin_word_reg | DIR_MASK);

    always_comb
    begin
        pin_word_next     = pin_word_reg;
        phase_next        = phase_reg;
        pulses_left_next  = pulses_left_reg;
        tick_timer_next   = tick_timer_reg;
        active_motor_next = active_motor_reg;
        rejected          = 1'b0;
        done              = 1'b0;

        if (item.action == ACT_MOVE)
        begin
            if (phase_reg != PH_IDLE || item.motor >= NUM_MOTORS)
            begin
                rejected = 1'b1;
            end
            else
            begin
                active_motor_next = item.motor;
                pulses_left_next  = new_pulses;
                if (new_pulses == '0)
                begin
                    pin_word_next = dir_word;
                    if (cfg.settle_time == '0)
                    begin
                        phase_next      = PH_IDLE;
                        tick_timer_next = '0;
                    end
                    else
                    begin
                        phase_next      = PH_SETTLE;
                        tick_timer_next = cfg.settle_time;
                    end
                end
                else
                begin
                    pin_word_next   = dir_word | new_mask;
                    phase_next      = PH_HIGH;
                    tick_timer_next = period_load;
                end
            end
        end
        else if (phase_reg != PH_IDLE)
        begin
            tick_timer_next = expired ? '0 : tick_timer_reg - TIMER_W'(1);
            if (expired)
            begin
                unique case (phase_reg)
                    PH_HIGH:
                    begin
                        pin_word_next   = pin_word_reg & ~pulse_mask;
                        phase_next      = PH_LOW;
                        tick_timer_next = period_load;
                    end
                    PH_LOW:
                    begin
                        pulses_left_next = pulses_dec;
                        if (pulses_dec != '0)
                        begin
                            pin_word_next   = pin_word_reg | pulse_mask;
                            phase_next      = PH_HIGH;
                            tick_timer_next = period_load;
                        end
                        else if (cfg.settle_time == '0)
                        begin
                            phase_next      = PH_IDLE;
                            tick_timer_next = '0;
                            done            = 1'b1;
                        end
                        else
                        begin
                            phase_next      = PH_SETTLE;
                            tick_timer_next = cfg.settle_time;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                        done       = 1'b1;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pin_word_reg     <= '0;
            phase_reg        <= PH_IDLE;
            pulses_left_reg  <= '0;
            tick_timer_reg   <= '0;
            active_motor_reg <= '0;
        end
        else if (step)
        begin
            pin_word_reg     <= pin_word_next;
            phase_reg        <= phase_next;
            pulses_left_reg  <= pulses_left_next;
            tick_timer_reg   <= tick_timer_next;
            active_motor_reg <= active_motor_next;
        end
    end

    assign res.pins      = pin_word_next;
    assign res.busy_res  = (phase_next != PH_IDLE);
    assign res.rejected  = rejected;
    assign res.move_done = done;

`ifndef SYNTH
    a_reject_holds: assert property (@(posedge clk) disable iff (!rst_n)
        step && rejected |=> $stable(pin_word_reg) && $stable(phase_reg))
        else $error("rejected command changed state");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        step && done |=> phase_reg == PH_IDLE)
        else $error("move_done without returning to idle");

    a_no_step_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !step |=> $stable(phase_reg) && $stable(pin_word_reg) && $stable(tick_timer_reg))
        else $error("state moved without a beat");

    a_high_pin: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_HIGH |-> pin_word_reg[pulse_idx])
        else $error("pulse pin low during high phase");
`endif

endmodule

// ----- design/stp_out_reg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stp_out_reg
// Result register: holds one result beat until the consumer takes it.
// ----------------------------------------------------------------------------
module stp_out_reg (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load,
    input  stp_pkg::out_beat_t   res,
    output logic                 out_valid,
    input  logic                 out_ready,
    output stp_pkg::out_beat_t   out_data
);
    import stp_pkg::*;

    logic      valid_reg, valid_next;
    out_beat_t data_reg;

    always_comb
    begin
        priority if (load)
            valid_next = 1'b1;
        else if (out_ready)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= res;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ----- design/stepper_turn_pulse_sequencer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stepper_turn_pulse_sequencer
// Step/direction pulse sequencer for six stepper motors on a 12-bit pin word.
// ----------------------------------------------------------------------------
// Takes one beat per clock: a move command or a time tick. Each beat lands in
// an input register, passes the combinational state update and is written to
// the result register, and the block sustains one beat per cycle as long as
// results are taken; a stalled result register holds the input register,
// which then holds the channel. Configuration is a plain write port (0 half
// period, 1 pulses per quarter turn, 2 settle time) and must only be written
// while no beat is in flight.
module stepper_turn_pulse_sequencer (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [stp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [stp_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  stp_pkg::in_beat_t                in_data,
    output logic                             out_valid,
    input  logic                             out_ready,
    output stp_pkg::out_beat_t               out_data
);
    import stp_pkg::*;

    logic      in_valid_reg, in_valid_next;
    in_beat_t  in_data_reg;
    logic      advance;
    logic      step;
    logic      in_accept;
    cfg_t      cfg;
    out_beat_t res;

    assign advance   = !out_valid || out_ready;
    assign step      = in_valid_reg && advance;
    assign in_ready  = !in_valid_reg || advance;
    assign in_accept = in_valid && in_ready;

    always_comb
    begin
        priority if (in_accept)
            in_valid_next = 1'b1;
        else if (step)
            in_valid_next = 1'b0;
        else
            in_valid_next = in_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
            in_data_reg <= in_data;
    end

    stp_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    stp_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .item  (in_data_reg),
        .cfg   (cfg),
        .res   (res)
    );

    stp_out_reg u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (step),
        .res       (res),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

// ----- test/stepper_turn_pulse_sequencer_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stepper_turn_pulse_sequencer_test
// Self-checking bench for the six-motor step/direction pulse sequencer.
// ----------------------------------------------------------------------------
// A scoreboard object tracks the pin word, move phase, timers and settings of
// the block and predicts the result of every beat taken on the input channel;
// results are compared field by field in order of arrival. Stimulus starts
// with short directed moves (idle ticks, bad motors, busy commands, zero
// half period, zero step count, zero settle time, settings changed mid-move),
// runs one long quarter-turn move at the largest step count, then random
// phases of move commands and ticks with random settings, random gaps on
// both channels and a long output stall that backs the block up.
// ----------------------------------------------------------------------------
module stepper_turn_pulse_sequencer_test;

    import stp_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 2_000_000;

    class pin_scoreboard;
        logic [15:0]        half_period;
        logic [7:0]         quarter_steps;
        logic [15:0]        settle_time;
        logic [PIN_W-1:0]   pin_word;
        phase_t             phase;
        logic [PULSES_W-1:0] pulses_left;
        logic [TIMER_W-1:0] tick_timer;
        logic [MOTOR_W-1:0] active_motor;
        out_beat_t          pins_due[$];
        int unsigned        mismatches;
        int unsigned        results;
        int unsigned        moves;
        int unsigned        refusals;
        int unsigned        finishes;

        function new();
            half_period   = HALF_PERIOD_RST;
            quarter_steps = QUARTER_STEPS_RST;
            settle_time   = SETTLE_TIME_RST;
            pin_word      = '0;
            phase         = PH_IDLE;
            pulses_left   = '0;
            tick_timer    = '0;
            active_motor  = '0;
            mismatches    = 0;
            results       = 0;
            moves         = 0;
            refusals      = 0;
            finishes      = 0;
        endfunction

        function logic [TIMER_W-1:0] period_load();
            return (half_period == 16'd0) ? 16'd1 : half_period;
        endfunction

        function logic [PIN_W-1:0] step_bit();
            return 12'd1 << (2 * active_motor + 1);
        endfunction

        // returns 1 when the move ends right away
        function bit start_settle();
            if (settle_time == 16'd0)
            begin
                phase      = PH_IDLE;
                tick_timer = '0;
                return 1'b1;
            end
            phase      = PH_SETTLE;
            tick_timer = settle_time;
            return 1'b0;
        endfunction

        function void flag_error(string msg);
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: %s", msg);
        endfunction

        function void note_beat(in_beat_t b);
            out_beat_t want;
            bit        expired;
            want = '0;
            if (b.action == ACT_MOVE)
            begin
                if (phase != PH_IDLE || b.motor >= NUM_MOTORS)
                begin
                    want.rejected = 1'b1;
                    refusals++;
                end
                else
                begin
                    moves++;
                    if (b.direction == 1'b0)
                        pin_word |= DIR_MASK;
                    else
                        pin_word &= ~DIR_MASK;
                    active_motor = b.motor;
                    pulses_left  = {1'b0, quarter_steps} << b.half_turn;
                    if (pulses_left == '0)
                        void'(start_settle());
                    else
                    begin
                        pin_word  |= step_bit();
                        phase      = PH_HIGH;
                        tick_timer = period_load();
                    end
                end
            end
            else if (phase != PH_IDLE)
            begin
                expired    = tick_timer <= 16'd1;
                tick_timer = expired ? 16'd0 : tick_timer - 16'd1;
                if (expired)
                begin
                    case (phase)
                        PH_HIGH:
                        begin
                            pin_word  &= ~step_bit();
                            phase      = PH_LOW;
                            tick_timer = period_load();
                        end
                        PH_LOW:
                        begin
                            if (pulses_left != '0)
                                pulses_left = pulses_left - PULSES_W'(1);
                            if (pulses_left != '0)
                            begin
                                pin_word  |= step_bit();
                                phase      = PH_HIGH;
                                tick_timer = period_load();
                            end
                            else if (start_settle())
                                want.move_done = 1'b1;
                        end
                        default:
                        begin
                            phase          = PH_IDLE;
                            want.move_done = 1'b1;
                        end
                    endcase
                end
            end
            if (want.move_done)
                finishes++;
            want.pins     = pin_word;
            want.busy_res = (phase != PH_IDLE);
            pins_due.push_back(want);
        endfunction

        function void check_beat(out_beat_t got);
            out_beat_t want;
            results++;
            if (pins_due.size() == 0)
            begin
                flag_error($sformatf("result with nothing pending: pins %h busy %b rej %b done %b",
                                     got.pins, got.busy_res, got.rejected, got.move_done));
                return;
            end
            want = pins_due.pop_front();
            if (got.pins !== want.pins || got.busy_res !== want.busy_res ||
                got.rejected !== want.rejected || got.move_done !== want.move_done)
                flag_error($sformatf({"pins %h/%h busy %b/%b rej %b/%b done %b/%b",
                                      " (expected/actual)"},
                                     want.pins, got.pins, want.busy_res, got.busy_res,
                                     want.rejected, got.rejected, want.move_done,
                                     got.move_done));
        endfunction
    endclass

    logic      clk;
    logic      rst_n;
    logic      cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic      in_valid;
    logic      in_ready;
    in_beat_t  in_data;
    logic      out_valid;
    logic      out_ready;
    out_beat_t out_data;

    pin_scoreboard board;
    bit            idling;
    bit            hold_req;
    int unsigned   beats_sent;
    int unsigned   cycles = 0;

    stepper_turn_pulse_sequencer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results pending",
                     cycles, board.pins_due.size());
            $display("FAIL");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            board.check_beat(out_data);
    end

    // result side: random stalls, plus one long hold on request
    initial
    begin
        int unsigned left;
        logic        level;
        left      = 0;
        level     = 1'b0;
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                level    = 1'b0;
                left     = 400;
            end
            else if (left > 0)
                left--;
            if (left == 0)
            begin
                if (idling && $urandom_range(0, 2) == 0)
                begin
                    level = 1'b0;
                    left  = $urandom_range(1, 19);
                end
                else
                begin
                    level = 1'b1;
                    left  = $urandom_range(1, 30);
                end
            end
            out_ready <= level;
        end
    end

    task automatic send_beat(input logic act, input logic [MOTOR_W-1:0] m,
                             input logic d, input logic h);
        in_beat_t b;
        b.action    = act;
        b.motor     = m;
        b.direction = d;
        b.half_turn = h;
        if (idling && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= b;
        do
        begin
            @(posedge clk);
        end while (!in_ready);
        board.note_beat(b);
        beats_sent++;
    endtask

    task automatic send_tick();
        logic [MOTOR_W-1:0] m;
        m = MOTOR_W'($urandom_range(0, 7));
        send_beat(ACT_TICK, m, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    endtask

    task automatic finish_move();
        while (board.phase != PH_IDLE)
            send_tick();
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (board.pins_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic load_setting(input logic [15:0] hp, input logic [7:0] qs,
                                input logic [15:0] st);
        cfg_we    <= 1'b1;
        cfg_index <= REG_HALF_PERIOD;
        cfg_data  <= hp;
        @(posedge clk);
        cfg_index <= REG_QUARTER_STEPS;
        cfg_data  <= {8'h00, qs};
        @(posedge clk);
        cfg_index <= REG_SETTLE_TIME;
        cfg_data  <= st;
        @(posedge clk);
        cfg_we <= 1'b0;
        board.half_period   = hp;
        board.quarter_steps = qs;
        board.settle_time   = st;
    endtask

    task automatic random_beat();
        int unsigned        roll;
        logic [MOTOR_W-1:0] m;
        roll = $urandom_range(0, 99);
        if (board.phase == PH_IDLE ? roll < 45 : roll < 8)
        begin
            if (roll < 3)
                m = MOTOR_W'($urandom_range(6, 7));
            else
                m = MOTOR_W'($urandom_range(0, 5));
            send_beat(ACT_MOVE, m, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end
        else
            send_tick();
    endtask

    initial
    begin
        logic [15:0] hp;
        logic [7:0]  qs;
        logic [15:0] st;
        board      = new();
        beats_sent = 0;
        idling     = 1'b1;
        hold_req   = 1'b0;
        rst_n      = 1'b0;
        cfg_we     = 1'b0;
        cfg_index  = REG_HALF_PERIOD;
        cfg_data   = '0;
        in_valid   = 1'b0;
        in_data    = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed moves on short timing
        load_setting(16'd1, 8'd2, 16'd1);
        send_tick();
        send_beat(ACT_MOVE, 3'd6, 1'b0, 1'b0);
        send_beat(ACT_MOVE, 3'd7, 1'b1, 1'b1);
        send_beat(ACT_MOVE, 3'd0, 1'b0, 1'b0);
        send_beat(ACT_MOVE, 3'd2, 1'b1, 1'b1);
        finish_move();
        send_beat(ACT_MOVE, 3'd5, 1'b1, 1'b1);
        finish_move();

        // zero half period, zero step count, zero settle time
        drain();
        load_setting(16'd0, 8'd0, 16'd0);
        send_beat(ACT_MOVE, 3'd3, 1'b0, 1'b1);
        send_tick();
        drain();
        load_setting(16'd0, 8'd1, 16'd0);
        send_beat(ACT_MOVE, 3'd1, 1'b1, 1'b0);
        finish_move();

        // settings rewritten while a move runs
        drain();
        load_setting(16'd2, 8'd0, 16'd3);
        send_beat(ACT_MOVE, 3'd2, 1'b0, 1'b0);
        drain();
        load_setting(16'd1, 8'd1, 16'd1);
        finish_move();
        drain();
        load_setting(16'd3, 8'd2, 16'd2);
        send_beat(ACT_MOVE, 3'd4, 1'b0, 1'b1);
        send_tick();
        send_tick();
        drain();
        load_setting(16'd1, 8'd3, 16'd0);
        finish_move();

        // largest quarter-turn step count, back to back
        idling = 1'b0;
        drain();
        load_setting(16'd1, 8'hFF, 16'd0);
        send_beat(ACT_MOVE, 3'd5, 1'b0, 1'b0);
        finish_move();
        idling = 1'b1;

        // random phases
        for (int ph = 0; ph < 9; ph++)
        begin
            drain();
            if (ph == 8)
                idling = 1'b0;
            hp = 16'($urandom_range(0, 3));
            qs = (ph % 4 == 3) ? 8'($urandom_range(6, 30)) : 8'($urandom_range(0, 5));
            st = (ph % 3 == 2) ? 16'($urandom_range(7, 60)) : 16'($urandom_range(0, 6));
            load_setting(hp, qs, st);
            if (ph == 1)
                hold_req = 1'b1;
            repeat (66) random_beat();
        end

        drain();
        repeat (10) @(posedge clk);
        if (board.pins_due.size() != 0)
            board.flag_error($sformatf("%0d results never arrived", board.pins_due.size()));
        $display("sent %0d beats, checked %0d results", beats_sent, board.results);
        $display("moves taken %0d, commands refused %0d, moves finished %0d, mismatches %0d",
                 board.moves, board.refusals, board.finishes, board.mismatches);
        if (board.mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ----- stepper_turn_pulse_sequencer.f -----
design/stp_pkg.sv
design/stp_cfg_regs.sv
design/stp_core.sv
design/stp_out_reg.sv
design/stepper_turn_pulse_sequencer.sv
test/stepper_turn_pulse_sequencer_test.sv
